>>> hw/rtl/hav_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hav_pkg;

  // fixed-point anchors
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;
  localparam logic [63:0] PI4_Q60 = 64'h0C90_FDAA_2216_8C23;

  // degrees*1e7 to radians Q92
  localparam logic [63:0] DEG_Q92 = 64'd8642451851119134904;

  // angle folding limits in degrees*1e7
  localparam logic [31:0] QUARTER_TURN = 32'd900000000;
  localparam logic [31:0] HALF_TURN    = 32'd1800000000;
  localparam logic [31:0] FULL_TURN    = 32'd3600000000;

  // twice the earth radius in cm, and the distance ceiling
  localparam logic [31:0] TWO_R_CM = 32'd1274200000;
  localparam logic [30:0] DIST_MAX = 31'd2002000000;

  // reference point after reset
  localparam logic signed [30:0] REF_LAT_RESET = 31'sd411050780;
  localparam logic signed [31:0] REF_LON_RESET = 32'sd290235790;

  // configuration register indexes
  typedef enum logic {
    REG_REF_LATITUDE  = 1'b0,
    REG_REF_LONGITUDE = 1'b1
  } reg_index_t;

  // restoring long division, elaboration use only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], n[k]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i in Q60 from the odd power series
  function automatic logic signed [63:0] atan_pow2(input int i);
    logic signed [63:0] sum;
    logic [63:0] term;
    sum = '0;
    if (i == 0) begin
      return $signed(PI4_Q60);
    end
    for (int k = 0; k < 31; k++) begin
      if ((2 * k + 1) * i <= 60) begin
        term = udiv(64'd1 << (60 - (2 * k + 1) * i), 64'(2 * k + 1));
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    return sum;
  endfunction

  // inverse square of the cordic gain in Q60
  function automatic logic [63:0] k2_value(input int steps);
    logic [63:0] k2;
    k2 = ONE_Q60;
    for (int i = 0; i < 60; i++) begin
      if (i < steps && 2 * i <= 62) begin
        k2 = k2 - udiv(k2, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    return k2;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hav_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hav_cell #(
  parameter int SHIFT  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] x_in,
  input  logic signed [63:0] y_in,
  input  logic signed [63:0] z_in,
  output logic signed [63:0] x,
  output logic signed [63:0] y,
  output logic signed [63:0] z
);

  localparam logic signed [63:0] ANGLE = hav_pkg::atan_pow2(SHIFT);

  logic signed [63:0] dx;
  logic signed [63:0] dy;
  logic               ccw;

  // shifted cross terms and rotation direction
  assign dx  = y_in >>> SHIFT;
  assign dy  = x_in >>> SHIFT;
  assign ccw = VECTOR ? y_in[63] : ~z_in[63];

  // one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ANGLE;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ANGLE;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hav_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module hav_cordic #(
  parameter int STAGES = 24,
  parameter int LANES  = 1,
  parameter bit VECTOR = 1'b0,
  parameter int TAG_W  = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [63:0] x_in [LANES],
  input  logic signed [63:0] y_in [LANES],
  input  logic signed [63:0] z_in [LANES],
  input  logic [TAG_W-1:0]   tag_in,
  output logic signed [63:0] x [LANES],
  output logic signed [63:0] y [LANES],
  output logic signed [63:0] z [LANES],
  output logic [TAG_W-1:0]   tag_out
);

  logic signed [63:0] xs [STAGES][LANES];
  logic signed [63:0] ys [STAGES][LANES];
  logic signed [63:0] zs [STAGES][LANES];
  logic [TAG_W-1:0]   tg [STAGES];

  // side data travels alongside the vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        tg[k] <= '0;
      end
    end else if (en) begin
      tg[0] <= tag_in;
      for (int k = 1; k < STAGES; k++) begin
        tg[k] <= tg[k-1];
      end
    end
  end

  assign tag_out = tg[STAGES-1];

  // row of cells, one per iteration and lane
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [63:0] xi;
      logic signed [63:0] yi;
      logic signed [63:0] zi;

      if (s == 0) begin : g_first
        assign xi = x_in[l];
        assign yi = y_in[l];
        assign zi = z_in[l];
      end else begin : g_next
        assign xi = xs[s-1][l];
        assign yi = ys[s-1][l];
        assign zi = zs[s-1][l];
      end

      hav_cell #(
        .SHIFT  (s),
        .VECTOR (VECTOR)
      ) u_cell (
        .clk  (clk),
        .en   (en),
        .x_in (xi),
        .y_in (yi),
        .z_in (zi),
        .x    (xs[s][l]),
        .y    (ys[s][l]),
        .z    (zs[s][l])
      );
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign x[l] = xs[STAGES-1][l];
    assign y[l] = ys[STAGES-1][l];
    assign z[l] = zs[STAGES-1][l];
  end

endmodule

`default_nettype wire

>>> hw/rtl/hav_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module hav_mul #(
  parameter int LANES = 1,
  parameter int SHIFT = 60,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [63:0] a [LANES],
  input  logic signed [63:0] b [LANES],
  input  logic [TAG_W-1:0]   tag_in,
  output logic signed [63:0] p [LANES],
  output logic [TAG_W-1:0]   tag_out
);

  logic [TAG_W-1:0] tg [4];

  // side data, five stages deep like the product
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        tg[k] <= '0;
      end
      tag_out <= '0;
    end else if (en) begin
      tg[0] <= tag_in;
      for (int k = 1; k < 4; k++) begin
        tg[k] <= tg[k-1];
      end
      tag_out <= tg[3];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  p00;
    logic [63:0]  p01;
    logic [63:0]  p10;
    logic [63:0]  p11;
    logic [63:0]  q00;
    logic [63:0]  q11;
    logic [64:0]  mid;
    logic [127:0] full;
    logic [62:0]  mag;
    logic         n1;
    logic         n2;
    logic         n3;
    logic         n4;

    // full product from the partial products
    assign full = {q11, q00} + {31'b0, mid, 32'b0};

    always_ff @(posedge clk) begin
      if (en) begin
        // sign and magnitude
        ua <= a[l][63] ? 64'(-a[l]) : 64'(a[l]);
        ub <= b[l][63] ? 64'(-b[l]) : 64'(b[l]);
        n1 <= a[l][63] ^ b[l][63];
        // 32 by 32 partial products
        p00 <= ua[31:0]  * ub[31:0];
        p01 <= ua[31:0]  * ub[63:32];
        p10 <= ua[63:32] * ub[31:0];
        p11 <= ua[63:32] * ub[63:32];
        n2  <= n1;
        // middle column
        mid <= {1'b0, p01} + {1'b0, p10};
        q00 <= p00;
        q11 <= p11;
        n3  <= n2;
        // scale and drop the top bit
        mag <= full[SHIFT+62:SHIFT];
        n4  <= n3;
        // restore sign
        p[l] <= n4 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hav_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module hav_sqrt #(
  parameter int LANES = 2,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [62:0]      v_in [LANES],
  input  logic [TAG_W-1:0] tag_in,
  output logic [31:0]      root [LANES],
  output logic [TAG_W-1:0] tag_out
);

  localparam int STEPS = 32;

  logic [62:0]      vs [STEPS-1][LANES];
  logic [62:0]      rs [STEPS][LANES];
  logic [TAG_W-1:0] tg [STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STEPS; k++) begin
        tg[k] <= '0;
      end
    end else if (en) begin
      tg[0] <= tag_in;
      for (int k = 1; k < STEPS; k++) begin
        tg[k] <= tg[k-1];
      end
    end
  end

  assign tag_out = tg[STEPS-1];

  // one result bit per cell
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      localparam logic [62:0] BIT = 63'd1 << (62 - 2 * s);

      logic [62:0] vcur;
      logic [62:0] rcur;
      logic [62:0] trial;
      logic        take;

      if (s == 0) begin : g_first
        assign vcur = v_in[l];
        assign rcur = '0;
      end else begin : g_next
        assign vcur = vs[s-1][l];
        assign rcur = rs[s-1][l];
      end

      assign trial = rcur + BIT;
      assign take  = vcur >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rs[s][l] <= take ? (rcur >> 1) + BIT : rcur >> 1;
        end
      end

      // remainder is not needed after the last cell
      if (s < STEPS - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            vs[s][l] <= take ? vcur - trial : vcur;
          end
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign root[l] = rs[STEPS-1][l][31:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/haversine_distance_to_reference.sv
`timescale 1ns / 1ps
`default_nettype none

// throughput: one fix per cycle while the skid register is empty, set by the fully
// pipelined cordic rows and root cells
// a result waiting at the output is backed by a skid register, so one more fix is taken
// fixes with negative status leave the pipeline as bubbles and give no result
// reset clears all valid flags and loads the default reference point

module haversine_distance_to_reference #(
  parameter int ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic signed [2:0]  fix_status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [30:0]        distance_cm
);

  localparam logic signed [63:0] K2 = $signed(hav_pkg::k2_value(ITERATIONS));

  logic adv;

  logic signed [30:0] ref_latitude;
  logic signed [31:0] ref_longitude;

  logic               v0;
  logic signed [30:0] lat0;
  logic signed [31:0] lon0;
  logic               v1;
  logic [32:0]        ang1 [4];
  logic               v2;
  logic [31:0]        m2 [4];
  logic               v3;
  logic [31:0]        m3 [4];
  logic               v4;
  logic [31:0]        m4 [4];
  logic               v5;
  logic [31:0]        m5 [4];
  logic [1:0]         neg5;
  logic               v6;
  logic [63:0]        pl6 [4];
  logic [63:0]        ph6 [4];
  logic [1:0]         neg6;
  logic               v7;
  logic [95:0]        sum7 [4];
  logic signed [63:0] z7 [4];
  logic [1:0]         neg7;

  logic signed [63:0] rot_x0 [4];
  logic signed [63:0] rot_y0 [4];
  logic signed [63:0] rot_x [4];
  logic signed [63:0] rot_y [4];
  logic signed [63:0] rot_z [4];
  logic [2:0]         rot_tag;

  logic               v8;
  logic signed [63:0] s1_8;
  logic signed [63:0] s2_8;
  logic signed [63:0] c1_8;
  logic signed [63:0] c2_8;

  logic signed [63:0] ma_a [3];
  logic signed [63:0] ma_b [3];
  logic signed [63:0] ma_p [3];
  logic               ma_v;
  logic signed [63:0] mb_a [1];
  logic signed [63:0] mb_b [1];
  logic signed [63:0] mb_p [1];
  logic [64:0]        mb_tag;
  logic signed [63:0] k2_b [1];
  logic signed [63:0] mc_p [1];
  logic [64:0]        mc_tag;

  logic               v9;
  logic signed [63:0] w9;
  logic signed [63:0] md_a [1];
  logic signed [63:0] md_p [1];
  logic               md_v;

  logic               v10;
  logic [62:0]        a10;
  logic               v11;
  logic [62:0]        q11 [2];
  logic [31:0]        roots [2];
  logic               sq_v;

  logic signed [63:0] vec_x0 [1];
  logic signed [63:0] vec_y0 [1];
  logic signed [63:0] vec_z0 [1];
  logic signed [63:0] vec_x [1];
  logic signed [63:0] vec_y [1];
  logic signed [63:0] vec_z [1];
  logic               vec_v;

  logic               v12;
  logic [60:0]        zc12;
  logic               v13;
  logic [63:0]        pl13;
  logic [63:0]        ph13;
  logic               v14;
  logic [95:0]        sum14;
  logic [32:0]        q14;
  logic               v15;
  logic [33:0]        rnd15;
  logic [30:0]        d15;

  logic               sk_valid;
  logic [30:0]        sk_data;
  logic               push;
  logic               pop;

  // whole pipeline moves unless the skid register is occupied
  assign adv      = ~sk_valid;
  assign in_ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_latitude  <= hav_pkg::REF_LAT_RESET;
      ref_longitude <= hav_pkg::REF_LON_RESET;
    end else if (cfg_write) begin
      unique case (hav_pkg::reg_index_t'(cfg_index))
        hav_pkg::REG_REF_LATITUDE:  ref_latitude  <= $signed(cfg_data[30:0]);
        hav_pkg::REG_REF_LONGITUDE: ref_longitude <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // valid flags along the front end and tail
  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
      v15 <= 1'b0;
    end else if (adv) begin
      v0  <= in_valid & ~fix_status[2];
      v1  <= v0;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      v7  <= v6;
      v8  <= rot_tag[2];
      v9  <= mc_tag[64];
      v10 <= md_v;
      v11 <= v10;
      v12 <= vec_v;
      v13 <= v12;
      v14 <= v13;
      v15 <= v14;
    end
  end

  // angle preparation: differences, magnitude, folding, scaling
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sum7[l] = {ph6[l], 32'b0} + {32'b0, pl6[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat0 <= latitude;
      lon0 <= longitude;

      ang1[0] <= {{2{lat0[30]}}, lat0} - {{2{ref_latitude[30]}}, ref_latitude};
      ang1[1] <= {lon0[31], lon0} - {ref_longitude[31], ref_longitude};
      ang1[2] <= {{2{ref_latitude[30]}}, ref_latitude};
      ang1[3] <= {{2{lat0[30]}}, lat0};

      for (int l = 0; l < 4; l++) begin
        m2[l] <= ang1[l][32] ? ~ang1[l][31:0] + 32'd1 : ang1[l][31:0];
        m3[l] <= (m2[l] >= hav_pkg::FULL_TURN) ? m2[l] - hav_pkg::FULL_TURN : m2[l];
        m4[l] <= (m3[l] > hav_pkg::HALF_TURN) ? hav_pkg::FULL_TURN - m3[l] : m3[l];
        pl6[l] <= m5[l] * hav_pkg::DEG_Q92[31:0];
        ph6[l] <= m5[l] * hav_pkg::DEG_Q92[63:32];
      end

      // sine lanes keep the full angle here, halved when scaled into z7
      m5[0] <= m4[0];
      m5[1] <= m4[1];
      // cosine lanes fold into the first quadrant
      for (int l = 2; l < 4; l++) begin
        if (m4[l] > hav_pkg::QUARTER_TURN) begin
          m5[l]     <= hav_pkg::HALF_TURN - m4[l];
          neg5[l-2] <= 1'b1;
        end else begin
          m5[l]     <= m4[l];
          neg5[l-2] <= 1'b0;
        end
      end
      neg6 <= neg5;
      neg7 <= neg6;

      z7[0] <= $signed({1'b0, sum7[0][95:33]});
      z7[1] <= $signed({1'b0, sum7[1][95:33]});
      z7[2] <= $signed(sum7[2][95:32]);
      z7[3] <= $signed(sum7[3][95:32]);
    end
  end

  // sine and cosine rows
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rot_x0[l] = $signed(hav_pkg::ONE_Q60);
      rot_y0[l] = '0;
    end
  end

  hav_cordic #(
    .STAGES (ITERATIONS),
    .LANES  (4),
    .VECTOR (1'b0),
    .TAG_W  (3)
  ) u_rot (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .x_in    (rot_x0),
    .y_in    (rot_y0),
    .z_in    (z7),
    .tag_in  ({v7, neg7}),
    .x       (rot_x),
    .y       (rot_y),
    .z       (rot_z),
    .tag_out (rot_tag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_8 <= rot_y[0];
      s2_8 <= rot_y[1];
      c1_8 <= rot_tag[0] ? -rot_x[2] : rot_x[2];
      c2_8 <= rot_tag[1] ? -rot_x[3] : rot_x[3];
    end
  end

  // haversine term: products of cosines and half-angle sines
  always_comb begin
    ma_a[0] = c1_8;
    ma_b[0] = s2_8;
    ma_a[1] = c2_8;
    ma_b[1] = s2_8;
    ma_a[2] = s1_8;
    ma_b[2] = s1_8;
    mb_a[0] = ma_p[0];
    mb_b[0] = ma_p[1];
    k2_b[0] = K2;
    md_a[0] = w9;
  end

  hav_mul #(
    .LANES (3),
    .SHIFT (60),
    .TAG_W (1)
  ) u_mul_a (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .a       (ma_a),
    .b       (ma_b),
    .tag_in  (v8),
    .p       (ma_p),
    .tag_out (ma_v)
  );

  hav_mul #(
    .LANES (1),
    .SHIFT (60),
    .TAG_W (65)
  ) u_mul_b (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .a       (mb_a),
    .b       (mb_b),
    .tag_in  ({ma_v, ma_p[2]}),
    .p       (mb_p),
    .tag_out (mb_tag)
  );

  hav_mul #(
    .LANES (1),
    .SHIFT (60),
    .TAG_W (65)
  ) u_mul_c (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .a       (mb_p),
    .b       (k2_b),
    .tag_in  (mb_tag),
    .p       (mc_p),
    .tag_out (mc_tag)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      w9 <= $signed(mc_tag[63:0]) + mc_p[0];
    end
  end

  hav_mul #(
    .LANES (1),
    .SHIFT (58),
    .TAG_W (1)
  ) u_mul_d (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .a       (md_a),
    .b       (k2_b),
    .tag_in  (v9),
    .p       (md_p),
    .tag_out (md_v)
  );

  // clamp to the unit interval, then form both root operands
  always_ff @(posedge clk) begin
    if (adv) begin
      if (md_p[0][63]) begin
        a10 <= '0;
      end else if (md_p[0][62:0] > hav_pkg::ONE_Q62) begin
        a10 <= hav_pkg::ONE_Q62;
      end else begin
        a10 <= md_p[0][62:0];
      end
      q11[0] <= hav_pkg::ONE_Q62 - a10;
      q11[1] <= a10;
    end
  end

  hav_sqrt #(
    .LANES (2),
    .TAG_W (1)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .v_in    (q11),
    .tag_in  (v11),
    .root    (roots),
    .tag_out (sq_v)
  );

  // central angle by vectoring
  always_comb begin
    vec_x0[0] = $signed({3'b0, roots[0], 29'b0});
    vec_y0[0] = $signed({3'b0, roots[1], 29'b0});
    vec_z0[0] = '0;
  end

  hav_cordic #(
    .STAGES (ITERATIONS),
    .LANES  (1),
    .VECTOR (1'b1),
    .TAG_W  (1)
  ) u_vec (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .x_in    (vec_x0),
    .y_in    (vec_y0),
    .z_in    (vec_z0),
    .tag_in  (sq_v),
    .x       (vec_x),
    .y       (vec_y),
    .z       (vec_z),
    .tag_out (vec_v)
  );

  // scale to centimetres, round half up, saturate
  always_comb begin
    sum14 = {ph13, 32'b0} + {32'b0, pl13};
    rnd15 = {1'b0, q14} + 34'd1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zc12 <= vec_z[0][63] ? '0 : vec_z[0][60:0];
      pl13 <= zc12[31:0] * hav_pkg::TWO_R_CM;
      ph13 <= {3'b0, zc12[60:32]} * hav_pkg::TWO_R_CM;
      q14  <= sum14[91:59];
      d15  <= (rnd15[33:1] > {2'b0, hav_pkg::DIST_MAX}) ? hav_pkg::DIST_MAX : rnd15[31:1];
    end
  end

  // output register with skid stage
  assign push = adv & v15;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (pop || !out_valid) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      distance_cm <= sk_valid ? sk_data : d15;
    end
    if (push && out_valid && !pop) begin
      sk_data <= d15;
    end
  end

  // checks
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> out_valid)
    else $error("skid register holds a transaction while the output is empty");

  a_dist_ceiling : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_cm <= hav_pkg::DIST_MAX)
    else $error("distance above ceiling");

  a_nofix_dropped : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && fix_status[2] |=> !v0)
    else $error("fix without position entered the pipeline");

  a_term_clamped : assert property (@(posedge clk) disable iff (rst)
    v11 |-> a10 <= hav_pkg::ONE_Q62)
    else $error("haversine term outside unit interval");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v15) && $stable(d15))
    else $error("last stage moved during stall");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ITER      = 24;
  localparam int STEPS     = (ITER > 60) ? 60 : ITER;
  localparam int SETTLE    = 68 + 2 * ITER + 20;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [2:0]  status;
  } fix_t;

  logic                cfg_write;
  logic                clk;
  logic                rst;
  hav_pkg::reg_index_t cfg_index;
  logic [31:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic signed [30:0]  latitude;
  logic signed [31:0]  longitude;
  logic signed [2:0]   fix_status;
  logic                out_valid;
  logic                out_ready;
  logic [30:0]         distance_cm;

  haversine_distance_to_reference #(.ITERATIONS(ITER)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .latitude(latitude), .longitude(longitude), .fix_status(fix_status),
    .out_valid(out_valid), .out_ready(out_ready), .distance_cm(distance_cm)
  );

  // reference point as the block should hold it
  longint ref_lat_q;
  longint ref_lon_q;
  longint atan_tab[0:63];
  logic [63:0] gain_k2;

  fix_t        fix_queue[$];
  logic [30:0] dist_expected[$];
  int errors, fixes_sent, dists_checked, no_fix_count, ref_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  function automatic longint signed_mul(longint a, longint b, int s);
    logic        neg;
    logic [63:0] ua, ub, r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    r   = mul_shift(ua, ub, s) & 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint atan_entry(int i);
    longint sum, term;
    sum = 0;
    if (i == 0) return longint'(hav_pkg::PI4_Q60);
    for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
      term = longint'(64'd1 << (60 - (2 * k + 1) * i)) / longint'(2 * k + 1);
      sum  = (k % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic void cordic_rotate(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = longint'(hav_pkg::ONE_Q60);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end
    end
    return z;
  endfunction

  // magnitude folded into [0, half turn]
  function automatic logic [63:0] fold_angle(longint a);
    logic [63:0] m;
    m = (a < 0) ? -a : a;
    m = m % 64'(hav_pkg::FULL_TURN);
    if (m > 64'(hav_pkg::HALF_TURN)) m = 64'(hav_pkg::FULL_TURN) - m;
    return m;
  endfunction

  function automatic longint half_angle_sin(longint diff);
    longint c, s;
    cordic_rotate(longint'(mul_shift(fold_angle(diff), hav_pkg::DEG_Q92, 33)), c, s);
    return s;
  endfunction

  function automatic longint latitude_cos(longint lat);
    logic [63:0] m;
    logic        neg;
    longint      c, s;
    m   = fold_angle(lat);
    neg = 1'b0;
    if (m > 64'(hav_pkg::QUARTER_TURN)) begin
      m   = 64'(hav_pkg::HALF_TURN) - m;
      neg = 1'b1;
    end
    cordic_rotate(longint'(mul_shift(m, hav_pkg::DEG_Q92, 32)), c, s);
    return neg ? -c : c;
  endfunction

  function automatic logic [30:0] predict_distance(longint lat, longint lon);
    longint s1, s2, c1, c2, t, u, v, w, a, z;
    logic [63:0] d;
    s1 = half_angle_sin(lat - ref_lat_q);
    s2 = half_angle_sin(lon - ref_lon_q);
    c1 = latitude_cos(ref_lat_q);
    c2 = latitude_cos(lat);
    t  = signed_mul(c1, s2, 60);
    u  = signed_mul(c2, s2, 60);
    v  = signed_mul(signed_mul(t, u, 60), longint'(gain_k2), 60);
    w  = signed_mul(s1, s1, 60) + v;
    a  = signed_mul(w, longint'(gain_k2), 58);
    if (a < 0) a = 0;
    if (a > longint'(hav_pkg::ONE_Q62)) a = longint'(hav_pkg::ONE_Q62);
    z = cordic_angle(longint'(int_sqrt(64'(longint'(hav_pkg::ONE_Q62) - a)) << 29),
                     longint'(int_sqrt(64'(a)) << 29));
    if (z < 0) z = 0;
    d = (mul_shift(64'(z), 64'(hav_pkg::TWO_R_CM), 59) + 1) >> 1;
    if (d > 64'(hav_pkg::DIST_MAX)) d = 64'(hav_pkg::DIST_MAX);
    return d[30:0];
  endfunction

  // ---------------- sender: bursts and gaps ----------------
  int burst_left, gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      latitude   <= '0;
      longitude  <= '0;
      fix_status <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        fixes_sent++;
        if (fix_status < 0) no_fix_count++;
        else dist_expected.push_back(predict_distance(longint'(latitude), longint'(longitude)));
        void'(fix_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (fix_queue.size() > 0) begin
        latitude   <= fix_queue[0].lat;
        longitude  <= fix_queue[0].lon;
        fix_status <= fix_queue[0].status;
        in_valid   <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver: stall pattern ----------------
  int stall_mode, stall_left;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(10, 120);
      end
      stall_left--;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (dist_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual distance_cm %0d",
                 $time, distance_cm);
      end else begin
        if (distance_cm !== dist_expected[0]) begin
          errors++;
          $display("%0t: distance_cm mismatch, expected %0d, actual %0d",
                   $time, dist_expected[0], distance_cm);
        end
        dists_checked++;
        void'(dist_expected.pop_front());
      end
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_fix(longint lat, longint lon, int st);
    fix_t f;
    f.lat    = lat[30:0];
    f.lon    = lon[31:0];
    f.status = st[2:0];
    fix_queue.push_back(f);
  endtask

  task automatic write_reg(hav_pkg::reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == hav_pkg::REG_REF_LATITUDE) ref_lat_q = longint'($signed(val[30:0]));
    else ref_lon_q = longint'($signed(val));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_reference(longint lat, longint lon);
    write_reg(hav_pkg::REG_REF_LATITUDE, 32'(lat));
    write_reg(hav_pkg::REG_REF_LONGITUDE, 32'(lon));
    ref_settings++;
  endtask

  task automatic drain;
    while (fix_queue.size() > 0 || in_valid || dist_expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly valid fixes, some near the reference, the antipode or the poles, some noise, some with no fix
  task automatic add_random_fixes(int n);
    longint lat, lon;
    int st, kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 11);
      st   = $urandom_range(0, 3);
      lat  = longint'($urandom_range(0, 1800000000)) - 900000000;
      lon  = longint'($urandom_range(0, 2000000000)) * 9 / 5 - 1800000000;
      case (kind)
        6: begin
          lat = ref_lat_q + longint'($urandom_range(0, 2000)) - 1000;
          lon = ref_lon_q + longint'($urandom_range(0, 2000)) - 1000;
        end
        7: begin
          lat = -ref_lat_q + longint'($urandom_range(0, 200)) - 100;
          lon = ref_lon_q + 1800000000 + longint'($urandom_range(0, 200)) - 100;
        end
        8: lat = ($urandom_range(0, 1) ? 900000000 : -900000000)
                 - longint'($urandom_range(0, 50000));
        9: begin
          lat = longint'($signed(31'($urandom())));
          lon = longint'($signed($urandom()));
          st  = $urandom_range(0, 7) - 4;
        end
        10: st = -int'($urandom_range(1, 4));
        default: ;
      endcase
      add_fix(lat, lon, st);
    end
  endtask

  initial begin
    errors = 0; fixes_sent = 0; dists_checked = 0; no_fix_count = 0; ref_settings = 1;
    for (int i = 0; i < 64; i++) atan_tab[i] = atan_entry(i);
    gain_k2 = 64'd1 << 60;
    for (int i = 0; i < STEPS; i++)
      if (2 * i <= 62) gain_k2 = gain_k2 - gain_k2 / ((64'd1 << (2 * i)) + 64'd1);
    ref_lat_q = longint'(hav_pkg::REF_LAT_RESET);
    ref_lon_q = longint'(hav_pkg::REF_LON_RESET);
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= hav_pkg::REG_REF_LATITUDE;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: statuses, reference itself, antipode, poles, field extremes
    add_fix(ref_lat_q, ref_lon_q, 0);
    add_fix(ref_lat_q, ref_lon_q, -1);
    add_fix(0, 0, -4);
    add_fix(0, 0, 1);
    add_fix(0, 0, 2);
    add_fix(0, 0, 3);
    add_fix(-ref_lat_q, ref_lon_q - 1800000000, 0);
    add_fix(900000000, 0, 0);
    add_fix(-900000000, 1800000000, 0);
    add_fix(0, -1800000000, 2);
    add_fix(0, 1800000000, 1);
    add_fix(1073741823, 2147483647, 0);
    add_fix(-1073741824, -2147483647 - 1, 3);
    add_fix(ref_lat_q + 1, ref_lon_q, 0);
    add_fix(ref_lat_q, ref_lon_q + 1, 0);
    add_fix(-1, -1, 0);
    add_random_fixes(130);
    drain();

    set_reference(-900000000, 1800000000);
    add_fix(900000000, 0, 0);
    add_fix(-900000000, -1800000000, 0);
    add_random_fixes(130);
    drain();

    set_reference(900000000, -1800000000);
    add_random_fixes(130);
    drain();

    set_reference(0, 0);
    add_fix(0, 1800000000, 0);
    add_random_fixes(130);
    drain();

    set_reference(longint'($signed(31'($urandom()))), longint'($signed($urandom())));
    add_random_fixes(130);
    drain();

    $display("fixes sent %0d (no-fix %0d), distances checked %0d", fixes_sent,
             no_fix_count, dists_checked);
    $display("reference points used %0d, including both latitude and longitude extremes",
             ref_settings);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
